// ----- rtl/tuning_knob_display_controller_core_macros.svh -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TUNING_KNOB_DISPLAY_CONTROLLER_CORE_MACROS_SVH
`define TUNING_KNOB_DISPLAY_CONTROLLER_CORE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define TKDC_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tkdc check failed");

// condition holds in the cycle after the trigger
`define TKDC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tkdc check failed");

`endif

// ----- rtl/tkdc_pkg.sv -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - package
// Widths, reset values, register indexes, shared structs and arithmetic.
// ---------------------------------------------------------------------------
package tkdc_pkg;

   localparam int FreqW   = 18;
   localparam int DriveW  = 12;
   localparam int StepW   = 10;
   localparam int OffsetW = 15;
   localparam int ShownW  = 14;
   localparam int CsrW    = 18;

   // configuration reset values
   localparam logic [StepW-1:0]   TuneStepReset = 10'd50;
   localparam logic [OffsetW-1:0] IfOffsetReset = 15'd10700;
   localparam logic [FreqW-1:0]   FreqMinReset  = 18'd200;
   localparam logic [FreqW-1:0]   FreqMaxReset  = 18'd170000;

   // state reset values
   localparam logic [FreqW-1:0]  FreqReset   = 18'd78400;
   localparam logic [DriveW-1:0] ManualReset = 12'd750;
   localparam logic [DriveW-1:0] DriveReset  = 12'd847;

   // drive limits and manual step
   localparam logic [DriveW-1:0] DriveLo    = 12'd100;
   localparam logic [DriveW-1:0] DriveHi    = 12'd3300;
   localparam logic [DriveW-1:0] ManualStep = 12'd10;

   // varicap: floor(f*7088/100000) as (f*VcRecip) >> VcShift, exact for 18-bit f
   localparam int VcShift = 31;
   localparam logic [27:0] VcRecip =
      28'(((64'd1 << VcShift) * 64'd7088 + 64'd99999) / 64'd100000);
   localparam logic [14:0] VcSub      = 15'd4709;
   localparam logic [14:0] VcLoScaled = 15'(4709 + 100);
   localparam logic [14:0] VcHiScaled = 15'(4709 + 3300);

   // divide by 100 as (x*Div100Recip) >> Div100Shift, exact for any freq + if_offset sum
   localparam int Div100Shift = 25;
   localparam logic [18:0] Div100Recip = 19'(((64'd1 << Div100Shift) + 64'd99) / 64'd100);

   // blanking masks
   localparam logic [7:0] BlankFour  = 8'b1111_0000;
   localparam logic [7:0] BlankThree = 8'b0111_0000;
   localparam logic [7:0] BlankTwo   = 8'b0011_0000;
   localparam logic [7:0] BlankOne   = 8'b0001_0000;

   typedef enum logic [1:0] {
      CSR_TUNE_STEP = 2'd0,
      CSR_IF_OFFSET = 2'd1,
      CSR_FREQ_MIN  = 2'd2,
      CSR_FREQ_MAX  = 2'd3
   } csr_index_type;

   typedef enum logic {
      EVT_KNOB   = 1'b0,
      EVT_BUTTON = 1'b1
   } event_type;

   typedef struct packed {
      logic [StepW-1:0]   tune_step;
      logic [OffsetW-1:0] if_offset;
      logic [FreqW-1:0]   freq_min;
      logic [FreqW-1:0]   freq_max;
   } cfg_type;

   // state after an event; drive is varicap(freq) when drive_is_vc, else drive_man
   typedef struct packed {
      logic [FreqW-1:0]  freq;
      logic [DriveW-1:0] manual_drive;
      logic [DriveW-1:0] drive_man;
      logic              drive_is_vc;
      logic              mode;
   } snap_type;

   typedef struct packed {
      logic [ShownW-1:0] shown;
      logic [DriveW-1:0] drive;
      logic [FreqW-1:0]  freq;
      logic              mode;
   } conv_type;

   // varicap compare value for a tuned frequency, clamped to the drive limits
   function automatic logic [DriveW-1:0] varicap_of(input logic [FreqW-1:0] f);
      logic [45:0] prod;
      logic [14:0] scaled;
      prod   = 46'(f) * 46'(VcRecip);
      scaled = prod[45:VcShift];
      if (scaled < VcLoScaled) begin
         varicap_of = DriveLo;
      end else if (scaled > VcHiScaled) begin
         varicap_of = DriveHi;
      end else begin
         varicap_of = DriveW'(scaled - VcSub);
      end
   endfunction

   // remapped segment code of one decimal digit
   function automatic logic [3:0] digit_code(input logic [3:0] d);
      case (d)
         4'd0:    digit_code = 4'd0;
         4'd1:    digit_code = 4'd1;
         4'd2:    digit_code = 4'd4;
         4'd3:    digit_code = 4'd5;
         4'd4:    digit_code = 4'd8;
         4'd5:    digit_code = 4'd9;
         4'd6:    digit_code = 4'd12;
         4'd7:    digit_code = 4'd13;
         4'd8:    digit_code = 4'd2;
         4'd9:    digit_code = 4'd3;
         default: digit_code = 4'd0;
      endcase
   endfunction

endpackage

// ----- rtl/tkdc_csr.sv -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - configuration registers
// Holds tune step, IF offset and frequency limits, written by index.
// ---------------------------------------------------------------------------
module tkdc_csr
   import tkdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wen,
   input  logic [1:0]      csr_index,
   input  logic [CsrW-1:0] csr_wdata,
   output cfg_type         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_TUNE_STEP: cfg_in.tune_step = csr_wdata[StepW-1:0];
            CSR_IF_OFFSET: cfg_in.if_offset = csr_wdata[OffsetW-1:0];
            CSR_FREQ_MIN:  cfg_in.freq_min  = csr_wdata[FreqW-1:0];
            CSR_FREQ_MAX:  cfg_in.freq_max  = csr_wdata[FreqW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tune_step <= TuneStepReset;
         cfg_ff.if_offset <= IfOffsetReset;
         cfg_ff.freq_min  <= FreqMinReset;
         cfg_ff.freq_max  <= FreqMaxReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/tkdc_update.sv -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - event register and state update
// Registers the incoming event and applies it to frequency, mode and drive.
// ---------------------------------------------------------------------------
module tkdc_update
   import tkdc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     req_type,
   input  logic     req_step_up,
   input  logic     down_ready,
   output logic     snap_valid,
   output snap_type snap
);

   logic      ev_valid_ff, ev_valid_in;
   event_type ev_type_ff, ev_type_in;
   logic      ev_up_ff, ev_up_in;
   logic      snap_valid_ff, snap_valid_in;
   snap_type  state_ff, state_in;

   logic              stage_ready;
   logic              fire;
   logic [FreqW:0]    nf;
   logic [DriveW:0]   nm;
   logic [DriveW-1:0] vc_now;

   // handshake: the state stage frees up when its result moves on
   assign stage_ready = !snap_valid_ff || down_ready;
   assign req_tready  = !ev_valid_ff || stage_ready;
   assign fire        = ev_valid_ff && stage_ready;

   // event register
   always_comb begin
      ev_valid_in = ev_valid_ff;
      ev_type_in  = ev_type_ff;
      ev_up_in    = ev_up_ff;
      if (req_tready) begin
         ev_valid_in = req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         ev_type_in = event_type'(req_type);
         ev_up_in   = req_step_up;
      end
   end

   // next frequency for a tune step: saturate at zero, then min, then max
   always_comb begin
      if (ev_up_ff) begin
         nf = {1'b0, state_ff.freq} + (FreqW+1)'(cfg.tune_step);
      end else if (state_ff.freq >= FreqW'(cfg.tune_step)) begin
         nf = (FreqW+1)'(state_ff.freq - FreqW'(cfg.tune_step));
      end else begin
         nf = '0;
      end
      if (nf < (FreqW+1)'(cfg.freq_min)) begin
         nf = (FreqW+1)'(cfg.freq_min);
      end
      if (nf > (FreqW+1)'(cfg.freq_max)) begin
         nf = (FreqW+1)'(cfg.freq_max);
      end
   end

   // next manual drive for a manual step
   always_comb begin
      if (ev_up_ff) begin
         nm = {1'b0, state_ff.manual_drive} + (DriveW+1)'(ManualStep);
      end else if (state_ff.manual_drive >= ManualStep) begin
         nm = (DriveW+1)'(state_ff.manual_drive - ManualStep);
      end else begin
         nm = '0;
      end
      if (nm < (DriveW+1)'(DriveLo)) begin
         nm = (DriveW+1)'(DriveLo);
      end
      if (nm > (DriveW+1)'(DriveHi)) begin
         nm = (DriveW+1)'(DriveHi);
      end
   end

   // varicap value always follows the held frequency
   assign vc_now = varicap_of(state_ff.freq);

   // state update
   always_comb begin
      state_in      = state_ff;
      snap_valid_in = snap_valid_ff;
      if (stage_ready) begin
         snap_valid_in = ev_valid_ff;
      end
      if (fire) begin
         case (ev_type_ff)
            EVT_BUTTON: begin
               state_in.mode = !state_ff.mode;
               if (!state_ff.mode) begin
                  state_in.manual_drive = vc_now;
               end
            end
            EVT_KNOB: begin
               if (state_ff.mode) begin
                  state_in.manual_drive = nm[DriveW-1:0];
                  state_in.drive_man    = nm[DriveW-1:0];
                  state_in.drive_is_vc  = 1'b0;
               end else if (nf[FreqW-1:0] != state_ff.freq) begin
                  state_in.freq        = nf[FreqW-1:0];
                  state_in.drive_is_vc = 1'b1;
               end
            end
            default: state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff            <= 1'b0;
         snap_valid_ff          <= 1'b0;
         state_ff.freq          <= FreqReset;
         state_ff.manual_drive  <= ManualReset;
         state_ff.drive_man     <= DriveReset;
         state_ff.drive_is_vc   <= 1'b1;
         state_ff.mode          <= 1'b0;
      end else begin
         ev_valid_ff   <= ev_valid_in;
         snap_valid_ff <= snap_valid_in;
         state_ff      <= state_in;
      end
   end

   // event payload, no reset
   always_ff @(posedge clock) begin
      ev_type_ff <= ev_type_in;
      ev_up_ff   <= ev_up_in;
   end

   // state registers stay put while their result waits downstream
   assign snap_valid = snap_valid_ff;
   assign snap       = state_ff;

endmodule

// ----- rtl/tkdc_convert.sv -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - value conversion stage
// Derives the shown value and the driven compare value from the state.
// ---------------------------------------------------------------------------
module tkdc_convert
   import tkdc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     snap_valid,
   input  snap_type snap,
   output logic     up_ready,
   input  logic     down_ready,
   output logic     conv_valid,
   output conv_type conv
);

   logic     conv_valid_ff, conv_valid_in;
   conv_type conv_ff, conv_in;

   logic [FreqW:0]     disp_sum;
   logic [2*FreqW+1:0] disp_prod;
   logic [ShownW-1:0]  disp_khz;

   assign up_ready = !conv_valid_ff || down_ready;

   // (freq + if_offset) / 100 through a reciprocal multiply
   assign disp_sum  = (FreqW+1)'(snap.freq) + (FreqW+1)'(cfg.if_offset);
   assign disp_prod = (2*FreqW+2)'(disp_sum) * (2*FreqW+2)'(Div100Recip);
   assign disp_khz  = ShownW'(disp_prod[2*FreqW+1:Div100Shift]);

   always_comb begin
      conv_valid_in = conv_valid_ff;
      conv_in       = conv_ff;
      if (up_ready) begin
         conv_valid_in = snap_valid;
      end
      if (up_ready && snap_valid) begin
         conv_in.shown = snap.mode ? ShownW'(snap.manual_drive) : disp_khz;
         conv_in.drive = snap.drive_is_vc ? varicap_of(snap.freq) : snap.drive_man;
         conv_in.freq  = snap.freq;
         conv_in.mode  = snap.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_valid_ff <= 1'b0;
      end else begin
         conv_valid_ff <= conv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      conv_ff <= conv_in;
   end

   assign conv_valid = conv_valid_ff;
   assign conv       = conv_ff;

endmodule

// ----- rtl/tkdc_digits.sv -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - digit split and result register
// Splits the shown value into remapped digits and holds the result.
// ---------------------------------------------------------------------------
module tkdc_digits
   import tkdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        conv_valid,
   input  conv_type    conv,
   output logic        up_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic        rsp_mode_ff, rsp_mode_in;

   logic [3:0] dig_th, dig_hu, dig_te, dig_on;
   logic [9:0] rem_th;
   logic [6:0] rem_hu;
   logic [7:0] disp_high, disp_low, disp_blank;

   assign up_ready = !rsp_valid_ff || rsp_tready;

   // decimal split by parallel compares, one digit after another
   always_comb begin
      logic [ShownW-1:0] x;
      logic [ShownW-1:0] sub_th;
      logic [9:0]        sub_hu;
      logic [6:0]        sub_te;
      x      = conv.shown;
      dig_th = '0;
      for (int k = 1; k < 10; k++) begin
         if (x >= ShownW'(k * 1000)) dig_th = 4'(k);
      end
      sub_th = ShownW'(dig_th) * ShownW'(1000);
      rem_th = 10'(x - sub_th);
      dig_hu = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem_th >= 10'(k * 100)) dig_hu = 4'(k);
      end
      sub_hu = 10'(dig_hu) * 10'd100;
      rem_hu = 7'(rem_th - sub_hu);
      dig_te = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem_hu >= 7'(k * 10)) dig_te = 4'(k);
      end
      sub_te = 7'(dig_te) * 7'd10;
      dig_on = 4'(rem_hu - sub_te);
   end

   // leading-zero blanking
   always_comb begin
      if (conv.shown > ShownW'(999)) begin
         disp_blank = BlankFour;
      end else if (conv.shown > ShownW'(99)) begin
         disp_blank = BlankThree;
      end else if (conv.shown > ShownW'(9)) begin
         disp_blank = BlankTwo;
      end else begin
         disp_blank = BlankOne;
      end
   end

   assign disp_high = {digit_code(dig_on), digit_code(dig_te)};
   assign disp_low  = {digit_code(dig_hu), digit_code(dig_th)};

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_mode_in  = rsp_mode_ff;
      if (up_ready) begin
         rsp_valid_in = conv_valid;
      end
      if (up_ready && conv_valid) begin
         rsp_data_in = {2'b00, conv.freq, conv.drive, disp_low, disp_blank, disp_high};
         rsp_mode_in = conv.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_mode_ff;

endmodule

// ----- rtl/tuning_knob_display_controller_core.sv -----
// An accepted event passes the event, state, conversion and result registers.
// Throughput: one event per cycle unless the result side stalls; the state
// loop closes in the update stage, whose frequency step, clamp and varicap
// multiply are combinational. Backpressure on the result side stalls stages
// only as far back as needed. Reset (synchronous, active high) clears all
// valids and restores config and state defaults; no clearing pass.
// ---------------------------------------------------------------------------
// Tuning knob display controller - top level
// Knob and button events in, display bytes, drive and frequency out.
// ---------------------------------------------------------------------------
module tuning_knob_display_controller_core
   import tkdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // event transaction
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // [0] step_up, [7:1] zero
   input  logic            req_tuser,   // [0] req_type
   // result transaction
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [55:0]     rsp_tdata,   // [7:0] display_high, [15:8] display_blank,
                                        // [23:16] display_low, [35:24] drive_value,
                                        // [53:36] tuned_freq, [55:54] zero
   output logic            rsp_tuser,   // [0] manual_mode
   // configuration writes
   input  logic            csr_wen,
   input  logic [1:0]      csr_index,
   input  logic [CsrW-1:0] csr_wdata
);

   cfg_type  cfg;
   snap_type snap;
   conv_type conv;
   logic     snap_valid;
   logic     conv_valid;
   logic     conv_ready;
   logic     digits_ready;

   tkdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tkdc_update u_update (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_type    (req_tuser),
      .req_step_up (req_tdata[0]),
      .down_ready  (conv_ready),
      .snap_valid  (snap_valid),
      .snap        (snap)
   );

   tkdc_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .snap_valid (snap_valid),
      .snap       (snap),
      .up_ready   (conv_ready),
      .down_ready (digits_ready),
      .conv_valid (conv_valid),
      .conv       (conv)
   );

   tkdc_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .conv_valid (conv_valid),
      .conv       (conv),
      .up_ready   (digits_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/tkdc_checker.sv -----
// ---------------------------------------------------------------------------
// Tuning knob display controller - port checker
// Watches the result port for stalls, drive range and manual-mode display.
// ---------------------------------------------------------------------------
`include "tuning_knob_display_controller_core_macros.svh"

module tkdc_checker
   import tkdc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic              rsp_stall;
   logic              manual_valid;
   logic [DriveW-1:0] rsp_drive;
   logic [7:0]        rsp_blank;
   logic              thous_ok;

   // result fields watched below
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign manual_valid = rsp_tvalid && rsp_tuser;
   assign rsp_drive    = rsp_tdata[35:24];
   assign rsp_blank    = rsp_tdata[15:8];
   // thousands digit code is that of 0 to 3
   assign thous_ok     = (rsp_tdata[19:16] inside {4'd0, 4'd1, 4'd4, 4'd5});

   // a stalled result transaction holds its payload
   `TKDC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // driven compare value stays inside the drive limits
   `TKDC_ASSERT_SAME(a_drive_range, rsp_tvalid, rsp_drive >= DriveLo && rsp_drive <= DriveHi)

   // manual drive is at least 100, so three or four digits are lit
   `TKDC_ASSERT_SAME(a_manual_blank, manual_valid, rsp_blank == BlankFour || rsp_blank == BlankThree)

   // manual drive is at most 3300
   `TKDC_ASSERT_SAME(a_manual_thousands, manual_valid, thous_ok)

endmodule

bind tuning_knob_display_controller_core tkdc_checker u_checker (.*);
